// ===== design/tiny_cpu_execute_step_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tiny CPU execute step
// Shared concurrent checks, clocked on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TINY_CPU_EXECUTE_STEP_MACROS_SVH
`define TINY_CPU_EXECUTE_STEP_MACROS_SVH

// Same-cycle implication
`define TCE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tce assertion failed");

// Next-cycle implication
`define TCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tce assertion failed");

`endif

// ===== design/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants of the tiny CPU execute step.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int DEF_NUM_REGS   = 16;
    localparam int DEF_DATA_WIDTH = 16;

    localparam int FUNC_W      = 4;
    localparam int IDX_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int PC_W        = 16;
    localparam int RES_W       = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // Instruction opcode nibble
    localparam logic [FUNC_W-1:0] FN_HALT = 4'h0;
    localparam logic [FUNC_W-1:0] FN_NOP  = 4'h1;
    localparam logic [FUNC_W-1:0] FN_JUMP = 4'h2;
    localparam logic [FUNC_W-1:0] FN_MOVE = 4'h3;
    localparam logic [FUNC_W-1:0] FN_ADD  = 4'h4;
    localparam logic [FUNC_W-1:0] FN_SUB  = 4'h5;
    localparam logic [FUNC_W-1:0] FN_MUL  = 4'h6;
    localparam logic [FUNC_W-1:0] FN_DIV  = 4'h7;
    localparam logic [FUNC_W-1:0] FN_MOD  = 4'h8;

    // Serial ALU operations
    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD
    } t_alu_op;

    // Request from the sequencer to the serial ALU
    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

// ===== design/tce_regfile.sv =====
// ----------------------------------------------------------------------------
// tce_regfile
// Working register file: one write port, one registered read port; entries
// never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module tce_regfile
    import tce_pkg::*;
#(
    parameter int NUM_REGS   = DEF_NUM_REGS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    localparam int RIDX_W    = $clog2(NUM_REGS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [RIDX_W-1:0]     i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [RIDX_W-1:0]     i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   r_valid;
    logic [DATA_WIDTH-1:0] r_rdata;

    // Track written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Write storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read, unwritten entries as zero
    always_ff @(posedge i_clk) begin
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tce_serial_alu.sv =====
// ----------------------------------------------------------------------------
// tce_serial_alu
// Iterative ALU: one bit per cycle. Add and subtract
// run bit-serially through one full adder, multiply by shift and add, divide
// and modulo by restoring division against the 8-bit memory byte.
// ----------------------------------------------------------------------------
module tce_serial_alu
    import tce_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    localparam int CNT_W     = $clog2(DATA_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_alu_req              i_req,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [BYTE_W-1:0]     i_b,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_result
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    t_alu_op               r_op, n_op;
    logic [DATA_WIDTH-1:0] r_a, n_a;
    logic [DATA_WIDTH-1:0] r_acc, n_acc;
    logic [BYTE_W-1:0]     r_b, n_b;
    logic [BYTE_W-1:0]     r_bsh, n_bsh;
    logic [BYTE_W-1:0]     r_rem, n_rem;
    logic                  r_carry, n_carry;

    logic                  w_y, w_sum, w_cout;
    logic [BYTE_W:0]       w_rem9, w_diff;
    logic                  w_ge;

    // Bit-serial adder and restoring divide step
    always_comb begin
        w_y    = (r_op == ALU_SUB) ? ~r_bsh[0] : r_bsh[0];
        w_sum  = r_a[0] ^ w_y ^ r_carry;
        w_cout = (r_a[0] & w_y) | (r_a[0] & r_carry) | (w_y & r_carry);
        w_rem9 = {r_rem, r_a[DATA_WIDTH-1]};
        w_ge   = (w_rem9 >= {1'b0, r_b});
        w_diff = w_rem9 - {1'b0, r_b};
    end

    // Next state of the iteration
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_a     = r_a;
        n_acc   = r_acc;
        n_b     = r_b;
        n_bsh   = r_bsh;
        n_rem   = r_rem;
        n_carry = r_carry;
        if (r_busy) begin
            case (r_op)
                ALU_ADD, ALU_SUB: begin
                    n_a     = {w_sum, r_a[DATA_WIDTH-1:1]};
                    n_carry = w_cout;
                    n_bsh   = {1'b0, r_bsh[BYTE_W-1:1]};
                end
                ALU_MUL: begin
                    n_acc = {r_acc[DATA_WIDTH-2:0], 1'b0}
                          + (r_a[DATA_WIDTH-1] ? DATA_WIDTH'(r_b) : '0);
                    n_a   = {r_a[DATA_WIDTH-2:0], 1'b0};
                end
                default: begin
                    n_rem = w_ge ? w_diff[BYTE_W-1:0] : w_rem9[BYTE_W-1:0];
                    n_a   = {r_a[DATA_WIDTH-2:0], w_ge};
                end
            endcase
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_op    = i_req.op;
            n_a     = i_a;
            n_acc   = '0;
            n_b     = i_b;
            n_bsh   = i_b;
            n_rem   = '0;
            n_carry = (i_req.op == ALU_SUB);
        end
    end

    // Hold control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op    <= n_op;
        r_a     <= n_a;
        r_acc   <= n_acc;
        r_b     <= n_b;
        r_bsh   <= n_bsh;
        r_rem   <= n_rem;
        r_carry <= n_carry;
    end

    // Select the finished result
    always_comb begin
        o_result = r_a;
        case (r_op)
            ALU_MUL: o_result = r_acc;
            ALU_MOD: begin
                o_result             = '0;
                o_result[BYTE_W-1:0] = r_rem;
            end
            default: o_result = r_a;
        endcase
    end

    assign o_done = r_done;

endmodule

// ===== design/tiny_cpu_execute_step.sv =====
// ----------------------------------------------------------------------------
// tiny_cpu_execute_step
// Executes one two-byte instruction per input transfer against a local
// register file and program counter; arithmetic runs on a bit-serial ALU.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload (low bit up)
//  s_axis   | in        | func[3:0] reg_index[7:4] operand[15:8] mem_data[23:16]
//  m_axis   | out       | halted[0] next_pc[16:1] reg_result[32:17], zero pad
//
//  Arithmetic opcodes pass through S_READ, S_START and S_WAIT, where the
//  one-bit-per-cycle ALU runs, before write-back; halt, no-op, move and jump skip S_WAIT.
//  The next transfer is accepted the cycle after write-back.
//  A finished result waits in the output register while the next instruction runs;
//  write-back stalls only while that register is still full.
//  Synchronous active-low reset clears the counter, state and valid bits.
// ----------------------------------------------------------------------------
`include "tiny_cpu_execute_step_macros.svh"

module tiny_cpu_execute_step
    import tce_pkg::*;
#(
    parameter int NUM_REGS   = DEF_NUM_REGS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // func, reg_index, operand, mem_data
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // halted, next_pc, reg_result, pad
);

    localparam int RIDX_W = $clog2(NUM_REGS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_WAIT,
        S_WB
    } t_state;

    t_state                r_state;
    logic [FUNC_W-1:0]     r_func;
    logic [RIDX_W-1:0]     r_sel;
    logic [BYTE_W-1:0]     r_operand;
    logic [BYTE_W-1:0]     r_mem;
    logic [PC_W-1:0]       r_pc;
    logic [PC_W-1:0]       r_next_pc;
    logic                  r_halted;
    logic [DATA_WIDTH-1:0] r_result;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                  w_accept;
    logic                  w_wb_fire;
    logic [IDX_W-1:0]      w_idx;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic                  w_alu_done;
    logic [DATA_WIDTH-1:0] w_alu_result;
    t_alu_req              w_alu_req;
    logic                  w_is_arith;
    logic                  w_is_halt;
    t_alu_op               w_alu_op;
    logic [RES_W-1:0]      w_res16;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_wb_fire     = (r_state == S_WB) && (!r_out_valid || m_axis_tready);

    // Wrap the register nibble into the register count
    always_comb begin
        w_idx = s_axis_tdata[7:4];
        for (int i = 0; i < 8; i++) begin
            if ({1'b0, w_idx} >= (IDX_W + 1)'(NUM_REGS)) begin
                w_idx = w_idx - IDX_W'(NUM_REGS);
            end
        end
    end

    // Decode opcode
    always_comb begin
        w_is_arith = 1'b0;
        w_is_halt  = 1'b0;
        w_alu_op   = ALU_ADD;
        unique case (r_func) inside
            FN_NOP, FN_MOVE, FN_JUMP: ;
            FN_ADD: begin w_is_arith = 1'b1; w_alu_op = ALU_ADD; end
            FN_SUB: begin w_is_arith = 1'b1; w_alu_op = ALU_SUB; end
            FN_MUL: begin w_is_arith = 1'b1; w_alu_op = ALU_MUL; end
            FN_DIV: begin w_is_arith = 1'b1; w_alu_op = ALU_DIV; end
            FN_MOD: begin w_is_arith = 1'b1; w_alu_op = ALU_MOD; end
            default: w_is_halt = 1'b1;
        endcase
    end

    assign w_alu_req = '{start: (r_state == S_START) && w_is_arith, op: w_alu_op};

    tce_regfile #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_wb_fire),
        .i_waddr (r_sel),
        .i_wdata (r_result),
        .i_raddr (r_sel),
        .o_rdata (w_rd_data)
    );

    tce_serial_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_a      (w_rd_data),
        .i_b      (r_mem),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    // Low 16 bits of the register, zero-extended if narrower, for the result port
    generate
        if (DATA_WIDTH >= RES_W) begin : g_res_trunc
            assign w_res16 = r_result[RES_W-1:0];
        end else begin : g_res_ext
            assign w_res16 = {{(RES_W - DATA_WIDTH){1'b0}}, r_result};
        end
    endgenerate

    // Sequencer, program counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load the output register on write-back, drop it once taken
            if (w_wb_fire) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {7'b0, w_res16, r_next_pc, r_halted};
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= w_is_arith ? S_WAIT : S_WB;
                end
                S_WAIT: begin
                    if (w_alu_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (w_wb_fire) begin
                        r_state <= S_IDLE;
                        r_pc    <= r_next_pc;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Capture the item, work out the counter and the register value
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func    <= s_axis_tdata[3:0];
            r_sel     <= w_idx[RIDX_W-1:0];
            r_operand <= s_axis_tdata[15:8];
            r_mem     <= s_axis_tdata[23:16];
        end
        if (r_state == S_START) begin
            r_result  <= w_rd_data;
            r_halted  <= w_is_halt;
            if (w_is_halt) begin
                r_next_pc <= '0;
            end else if (r_func == FN_JUMP) begin
                r_next_pc <= {{(PC_W - BYTE_W){1'b0}}, r_operand[BYTE_W-1:1], 1'b0};
            end else begin
                r_next_pc <= r_pc + PC_W'(2);
            end
        end
        // Modulo by zero keeps the register
        if ((r_state == S_WAIT) && w_alu_done) begin
            if ((r_func == FN_MOD) && (r_mem == '0)) begin
                r_result <= w_rd_data;
            end else begin
                r_result <= w_alu_result;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `TCE_ASSERT_IMPL(a_done_in_wait, w_alu_done, r_state == S_WAIT)
    `TCE_ASSERT_NEXT(a_accept_to_read, w_accept, r_state == S_READ)
    `TCE_ASSERT_NEXT(a_wb_loads_output, w_wb_fire, r_out_valid && r_state == S_IDLE)
    `TCE_ASSERT_NEXT(a_halt_clears_pc, w_wb_fire && r_halted, r_pc == '0)

endmodule
